[src/lfoe_pkg.sv]
// ----------------------------------------------------------------------------
// lfoe_pkg
// Shared constants, types and state codes for the linear fade-out envelope.
// ----------------------------------------------------------------------------
package lfoe_pkg;

   localparam int SAMPLE_BITS_DEFAULT    = 24;
   localparam int GAIN_FRAC_BITS_DEFAULT = 16;

   localparam int POS_BITS = 32;
   localparam logic [POS_BITS-1:0] POS_MAX = '1;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] REG_FADE_ENABLE = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FADE_START  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_FADE_STOP   = 2'd2;

   localparam int QUEUE_DEPTH = 2;

   // how the front classified a frame that goes on to the back
   typedef struct packed {
      logic                scale;
      logic                last;
      logic [POS_BITS-1:0] num;
      logic [POS_BITS-1:0] den;
   } frame_class_type;

   typedef struct packed {
      logic push;
      logic pop;
   } queue_ctrl_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      BACK_IDLE,
      BACK_DIV,
      BACK_MUL,
      BACK_PUT
   } back_state_type;

endpackage

[src/lfoe_req_if.sv]
// ----------------------------------------------------------------------------
// lfoe_req_if
// Request channel carrying one stereo frame.
// ----------------------------------------------------------------------------
interface lfoe_req_if
   import lfoe_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_sample;
   logic signed [SAMPLE_BITS-1:0] right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

[src/lfoe_rsp_if.sv]
// ----------------------------------------------------------------------------
// lfoe_rsp_if
// Response channel carrying one faded stereo frame and its last flag.
// ----------------------------------------------------------------------------
interface lfoe_rsp_if
   import lfoe_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] left_out;
   logic signed [SAMPLE_BITS-1:0] right_out;
   logic                          last;

   modport source (output valid, output left_out, output right_out, output last,
                   input ready);
   modport sink   (input valid, input left_out, input right_out, input last,
                   output ready);
endinterface

[src/lfoe_csr_if.sv]
// ----------------------------------------------------------------------------
// lfoe_csr_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lfoe_csr_if
   import lfoe_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic [CSR_INDEX_BITS-1:0] index;
   logic [CSR_DATA_BITS-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/lfoe_front.sv]
// ----------------------------------------------------------------------------
// lfoe_front
// Accepts frames, tracks position and finished, drops frames past the stop
// and classifies the rest for the back end. Holds the fade registers.
// ----------------------------------------------------------------------------
module lfoe_front
   import lfoe_pkg::*;
#(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
)(
   input  logic                          clock,
   input  logic                          reset,
   lfoe_req_if.sink                      req_bus,
   lfoe_csr_if.sink                      csr_bus,
   input  queue_status_type              queue_status,
   output logic                          push,
   output frame_class_type               frame_class,
   output logic signed [SAMPLE_BITS-1:0] left_sample,
   output logic signed [SAMPLE_BITS-1:0] right_sample
);

   logic                fade_enable_ff, fade_enable_in;
   logic [POS_BITS-1:0] fade_start_ff, fade_start_in;
   logic [POS_BITS-1:0] fade_stop_ff, fade_stop_in;
   logic [POS_BITS-1:0] position_ff, position_in;
   logic                finished_ff, finished_in;

   logic accept;
   logic past_stop;
   logic drop;

   assign req_bus.ready = !queue_status.full;
   assign csr_bus.ready = 1'b1;

   assign accept    = req_bus.valid && req_bus.ready;
   assign past_stop = position_ff >= fade_stop_ff;
   assign drop      = finished_ff || (fade_enable_ff && past_stop);
   assign push      = accept && !drop;

   assign left_sample  = req_bus.left_sample;
   assign right_sample = req_bus.right_sample;

   always_comb begin
      frame_class.scale = fade_enable_ff && (position_ff >= fade_start_ff);
      frame_class.last  = fade_enable_ff && (position_ff == fade_stop_ff - POS_BITS'(1));
      frame_class.num   = fade_stop_ff - position_ff;
      frame_class.den   = fade_stop_ff - fade_start_ff;
   end

   always_comb begin
      fade_enable_in = fade_enable_ff;
      fade_start_in  = fade_start_ff;
      fade_stop_in   = fade_stop_ff;
      if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.index)
            REG_FADE_ENABLE: fade_enable_in = csr_bus.data[0];
            REG_FADE_START:  fade_start_in  = csr_bus.data[POS_BITS-1:0];
            REG_FADE_STOP:   fade_stop_in   = csr_bus.data[POS_BITS-1:0];
            default:         ;
         endcase
      end
   end

   always_comb begin
      position_in = position_ff;
      finished_in = finished_ff;
      if (accept && !finished_ff && fade_enable_ff) begin
         if (past_stop) begin
            finished_in = 1'b1;
         end else if (position_ff != POS_MAX) begin
            position_in = position_ff + POS_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_enable_ff <= 1'b0;
         fade_start_ff  <= '0;
         fade_stop_ff   <= '0;
         position_ff    <= '0;
         finished_ff    <= 1'b0;
      end else begin
         fade_enable_ff <= fade_enable_in;
         fade_start_ff  <= fade_start_in;
         fade_stop_ff   <= fade_stop_in;
         position_ff    <= position_in;
         finished_ff    <= finished_in;
      end
   end

endmodule

[src/lfoe_queue.sv]
// ----------------------------------------------------------------------------
// lfoe_queue
// Short first-in first-out queue between the front and the back end.
// ----------------------------------------------------------------------------
module lfoe_queue
   import lfoe_pkg::*;
#(
   parameter int WIDTH = 8
)(
   input  logic             clock,
   input  logic             reset,
   input  queue_ctrl_type   ctrl,
   input  logic [WIDTH-1:0] push_data,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0]      slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  do_push;
   logic                  do_pop;

   assign status.full  = count_ff == COUNT_BITS'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign do_push      = ctrl.push && !status.full;
   assign do_pop       = ctrl.pop && !status.empty;
   assign pop_data     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_BITS'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/lfoe_back.sv]
// ----------------------------------------------------------------------------
// lfoe_back
// Computes the fade gain bit by bit, scales both channels and holds the
// response in an output register.
// ----------------------------------------------------------------------------
module lfoe_back
   import lfoe_pkg::*;
#(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEFAULT,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT
)(
   input  logic                          clock,
   input  logic                          reset,
   input  queue_status_type              queue_status,
   input  frame_class_type               frame_class,
   input  logic signed [SAMPLE_BITS-1:0] left_sample,
   input  logic signed [SAMPLE_BITS-1:0] right_sample,
   output logic                          pop,
   lfoe_rsp_if.source                    rsp_bus
);

   localparam int CNT_BITS  = $clog2(GAIN_FRAC_BITS);
   localparam int GAIN_BITS = GAIN_FRAC_BITS + 2;
   localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;

   back_state_type state_ff, state_in;

   logic                          load;
   logic                          div_step;
   logic                          mul_en;
   logic                          put;
   logic                          out_free;

   logic [CNT_BITS-1:0]           cnt_ff;
   logic [POS_BITS-1:0]           rem_ff;
   logic [POS_BITS-1:0]           den_ff;
   logic [GAIN_FRAC_BITS-1:0]     quot_ff;
   logic                          unity_ff;
   logic signed [SAMPLE_BITS-1:0] left_ff;
   logic signed [SAMPLE_BITS-1:0] right_ff;
   logic                          last_ff;
   logic                          scaled_ff;
   logic signed [PROD_BITS-1:0]   prod_l_ff;
   logic signed [PROD_BITS-1:0]   prod_r_ff;

   logic                          out_valid_ff, out_valid_in;
   logic signed [SAMPLE_BITS-1:0] out_left_ff;
   logic signed [SAMPLE_BITS-1:0] out_right_ff;
   logic                          out_last_ff;

   logic [POS_BITS:0]             rem_shift;
   logic                          rem_ge;
   logic [GAIN_BITS-1:0]          gain;
   logic signed [PROD_BITS-1:0]   shift_l;
   logic signed [PROD_BITS-1:0]   shift_r;

   assign out_free  = !out_valid_ff || rsp_bus.ready;
   assign rem_shift = {rem_ff, 1'b0};
   assign rem_ge    = rem_shift >= {1'b0, den_ff};
   assign gain      = {1'b0, unity_ff, quot_ff};
   assign shift_l   = prod_l_ff >>> GAIN_FRAC_BITS;
   assign shift_r   = prod_r_ff >>> GAIN_FRAC_BITS;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BACK_IDLE: begin
            if (!queue_status.empty) begin
               state_in = frame_class.scale ? BACK_DIV : BACK_PUT;
            end
         end
         BACK_DIV: begin
            if (cnt_ff == CNT_BITS'(GAIN_FRAC_BITS - 1)) begin
               state_in = BACK_MUL;
            end
         end
         BACK_MUL: state_in = BACK_PUT;
         BACK_PUT: begin
            if (out_free) begin
               state_in = BACK_IDLE;
            end
         end
         default: state_in = BACK_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      load     = 1'b0;
      div_step = 1'b0;
      mul_en   = 1'b0;
      put      = 1'b0;
      case (state_ff)
         BACK_IDLE: load     = !queue_status.empty;
         BACK_DIV:  div_step = 1'b1;
         BACK_MUL:  mul_en   = 1'b1;
         BACK_PUT:  put      = out_free;
         default:   ;
      endcase
   end

   assign pop = load;

   always_comb begin
      out_valid_in = out_valid_ff;
      if (put) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         left_ff   <= left_sample;
         right_ff  <= right_sample;
         last_ff   <= frame_class.last;
         scaled_ff <= frame_class.scale;
         den_ff    <= frame_class.den;
         cnt_ff    <= '0;
         quot_ff   <= '0;
         // numerator never exceeds the divisor, so the integer bit is equality
         unity_ff  <= frame_class.num >= frame_class.den;
         rem_ff    <= (frame_class.num >= frame_class.den) ? '0 : frame_class.num;
      end
      if (div_step) begin
         cnt_ff  <= cnt_ff + CNT_BITS'(1);
         quot_ff <= {quot_ff[GAIN_FRAC_BITS-2:0], rem_ge};
         rem_ff  <= rem_ge ? POS_BITS'(rem_shift - {1'b0, den_ff})
                           : rem_shift[POS_BITS-1:0];
      end
      if (mul_en) begin
         prod_l_ff <= left_ff * $signed(gain);
         prod_r_ff <= right_ff * $signed(gain);
      end
      if (put) begin
         out_left_ff  <= scaled_ff ? shift_l[SAMPLE_BITS-1:0] : left_ff;
         out_right_ff <= scaled_ff ? shift_r[SAMPLE_BITS-1:0] : right_ff;
         out_last_ff  <= last_ff;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.left_out  = out_left_ff;
   assign rsp_bus.right_out = out_right_ff;
   assign rsp_bus.last      = out_last_ff;

endmodule

[src/linear_fade_out_envelope.sv]
// ----------------------------------------------------------------------------
// linear_fade_out_envelope
// Linear fade-out gain ramp over a stereo frame stream with end cut.
// ----------------------------------------------------------------------------
// an unscaled frame passes the queue and the back end's idle and put states;
//   a faded one also passes its divide and multiply states
// faded frames are paced by the one-bit-a-cycle gain divider in the back end,
//   which takes a new frame only after the last one is put in its output register
// dropped frames give no response
// reset clears position, finished flag, fade registers, queue and output
module linear_fade_out_envelope
   import lfoe_pkg::*;
#(
   parameter int SAMPLE_BITS    = SAMPLE_BITS_DEFAULT,
   parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEFAULT
)(
   input  logic       clock,
   input  logic       reset,
   lfoe_req_if.sink   req_bus,
   lfoe_rsp_if.source rsp_bus,
   lfoe_csr_if.sink   csr_bus
);

   localparam int CLASS_BITS = $bits(frame_class_type);
   localparam int ENTRY_BITS = 2 * SAMPLE_BITS + CLASS_BITS;

   queue_ctrl_type                queue_ctrl;
   queue_status_type              queue_status;
   frame_class_type               front_class;
   frame_class_type               back_class;
   logic signed [SAMPLE_BITS-1:0] front_left;
   logic signed [SAMPLE_BITS-1:0] front_right;
   logic signed [SAMPLE_BITS-1:0] back_left;
   logic signed [SAMPLE_BITS-1:0] back_right;
   logic [ENTRY_BITS-1:0]         push_data;
   logic [ENTRY_BITS-1:0]         pop_data;
   logic                          push;
   logic                          pop;

   assign queue_ctrl.push = push;
   assign queue_ctrl.pop  = pop;
   assign push_data       = {front_left, front_right, front_class};
   assign back_left       = pop_data[ENTRY_BITS-1 -: SAMPLE_BITS];
   assign back_right      = pop_data[CLASS_BITS +: SAMPLE_BITS];
   assign back_class      = pop_data[CLASS_BITS-1:0];

   lfoe_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .csr_bus      (csr_bus),
      .queue_status (queue_status),
      .push         (push),
      .frame_class  (front_class),
      .left_sample  (front_left),
      .right_sample (front_right)
   );

   lfoe_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (queue_ctrl),
      .push_data (push_data),
      .pop_data  (pop_data),
      .status    (queue_status)
   );

   lfoe_back #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .frame_class  (back_class),
      .left_sample  (back_left),
      .right_sample (back_right),
      .pop          (pop),
      .rsp_bus      (rsp_bus)
   );

endmodule

[sim/fade_gain_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fade_gain_checker
// Watches the frame, response and register channels of the fade envelope,
// keeps its own copy of the fade registers and frame position, works out the
// faded frame for every accepted request that is not cut and compares each response with it.
// ----------------------------------------------------------------------------
module fade_gain_checker
   import lfoe_pkg::*;
(
   input  logic clock,
   input  logic reset,
   lfoe_req_if  req_mon,
   lfoe_rsp_if  rsp_mon,
   lfoe_csr_if  csr_mon,
   output int   outstanding,
   output int   fail_count
);

   localparam int SB = SAMPLE_BITS_DEFAULT;
   localparam int GF = GAIN_FRAC_BITS_DEFAULT;

   typedef struct {
      logic signed [SB-1:0] left_out;
      logic signed [SB-1:0] right_out;
      logic                 last;
   } faded_frame_type;

   faded_frame_type     faded_q[$];
   faded_frame_type     want;
   logic                fade_on;
   logic [POS_BITS-1:0] fade_begin;
   logic [POS_BITS-1:0] fade_end;
   logic [POS_BITS-1:0] position;
   logic                done;
   logic [63:0]         gain;
   int                  errors = 0;

   // product shifted right arithmetically, so negative samples floor
   function automatic logic signed [SB-1:0] scale_sample(input logic signed [SB-1:0] s,
                                                        input logic [63:0] g);
      longint product;
      product = longint'(s) * longint'(g);
      return SB'(product >>> GF);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fade_on    = 1'b0;
         fade_begin = '0;
         fade_end   = '0;
         position   = '0;
         done       = 1'b0;
         faded_q.delete();
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               REG_FADE_ENABLE: fade_on    = csr_mon.data[0];
               REG_FADE_START:  fade_begin = csr_mon.data;
               REG_FADE_STOP:   fade_end   = csr_mon.data;
               default: ;
            endcase
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            if (faded_q.size() == 0) begin
               errors++;
               $error("response with no request waiting: left_out %0d right_out %0d last %0b",
                      rsp_mon.left_out, rsp_mon.right_out, rsp_mon.last);
            end else begin
               want = faded_q.pop_front();
               if (rsp_mon.left_out !== want.left_out) begin
                  errors++;
                  $error("left_out mismatch: expected %0d, actual %0d",
                         want.left_out, rsp_mon.left_out);
               end
               if (rsp_mon.right_out !== want.right_out) begin
                  errors++;
                  $error("right_out mismatch: expected %0d, actual %0d",
                         want.right_out, rsp_mon.right_out);
               end
               if (rsp_mon.last !== want.last) begin
                  errors++;
                  $error("last mismatch: expected %0b, actual %0b", want.last, rsp_mon.last);
               end
            end
         end

         // once the end cut has happened nothing comes out again
         if (req_mon.valid && req_mon.ready && !done) begin
            want.left_out  = req_mon.left_sample;
            want.right_out = req_mon.right_sample;
            want.last      = 1'b0;
            if (!fade_on) begin
               faded_q.push_back(want);
            end else if (position >= fade_end) begin
               done = 1'b1;
            end else begin
               if (position >= fade_begin) begin
                  gain = ({32'd0, fade_end - position} << GF) / {32'd0, fade_end - fade_begin};
                  want.left_out  = scale_sample(req_mon.left_sample, gain);
                  want.right_out = scale_sample(req_mon.right_sample, gain);
               end
               want.last = (position == fade_end - 1'b1);
               faded_q.push_back(want);
               if (position != POS_MAX) position++;
            end
         end
      end
      outstanding <= faded_q.size();
      fail_count  <= errors;
   end

endmodule

[sim/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives stereo frames and fade register settings into the envelope: a
// directed pass over sample extremes, pass-through, ramps, stop below start
// and unity gain, then random ramps under varying back-pressure, ending with
// the end cut. The checker instance predicts and compares every response.
// ----------------------------------------------------------------------------
module testbench;
   import lfoe_pkg::*;

   localparam int SB            = SAMPLE_BITS_DEFAULT;
   localparam int RANDOM_FRAMES = 1150;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_STALL    = 400;

   localparam logic [CSR_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

   localparam logic signed [SB-1:0] SAMPLE_MAX = {1'b0, {(SB-1){1'b1}}};
   localparam logic signed [SB-1:0] SAMPLE_MIN = {1'b1, {(SB-1){1'b0}}};
   localparam logic signed [SB-1:0] BITS_0101  = {(SB/2){2'b01}};
   localparam logic signed [SB-1:0] BITS_1010  = {(SB/2){2'b10}};

   typedef enum int {
      FADE_TO_END,
      FADE_PAST_END,
      STOP_BELOW_START,
      WIDE_RAMP,
      UNITY_STEP,
      BYPASS
   } segment_shape_type;

   logic                clock;
   logic                reset;
   int                  outstanding;
   int                  fail_count;
   int                  send_idle_pct = 0;
   int                  take_idle_pct = 0;
   bit                  stall_request = 1'b0;
   logic                fade_on = 1'b0;
   logic [POS_BITS-1:0] frame_count = '0;

   lfoe_req_if req_ch();
   lfoe_rsp_if rsp_ch();
   lfoe_csr_if csr_ch();

   linear_fade_out_envelope dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_ch),
      .rsp_bus (rsp_ch),
      .csr_bus (csr_ch)
   );

   fade_gain_checker gain_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .csr_mon     (csr_ch),
      .outstanding (outstanding),
      .fail_count  (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("[linear_fade_out_envelope] ERROR");
      $finish;
   end

   // response side back-pressure, with one long hold on request
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (stall_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            stall_request = 1'b0;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= take_idle_pct);
         end
      end
   end

   function automatic logic signed [SB-1:0] random_sample();
      case ($urandom_range(7))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2: return SB'($urandom_range(8) - 4);
         default: return SB'($urandom());
      endcase
   endfunction

   task automatic send_frame(input logic signed [SB-1:0] left_s,
                             input logic signed [SB-1:0] right_s);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_ch.valid        <= 1'b1;
      req_ch.left_sample  <= left_s;
      req_ch.right_sample <= right_s;
      do @(posedge clock); while (!req_ch.ready);
      if (fade_on) frame_count++;
   endtask

   // wait for every expected response, then let dropped frames clear the pipe
   task automatic wait_results(input int extra);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (extra) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0]  data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= index;
      csr_ch.data  <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_fade(input logic en,
                               input logic [POS_BITS-1:0] fade_begin,
                               input logic [POS_BITS-1:0] fade_end);
      wait_results(SETTLE_CYCLES);
      // upper bits of the enable word must be ignored
      write_reg(REG_FADE_ENABLE, ($urandom() & ~32'd1) | 32'(en));
      write_reg(REG_FADE_START, fade_begin);
      write_reg(REG_FADE_STOP, fade_end);
      if ($urandom_range(3) == 0) write_reg(REG_UNUSED, $urandom());
      fade_on = en;
   endtask

   initial begin
      logic [POS_BITS-1:0] fade_begin;
      logic [POS_BITS-1:0] fade_end;
      segment_shape_type   shape;
      int                  n;
      int                  pause_at;
      int                  random_sent;

      reset               <= 1'b1;
      req_ch.valid        <= 1'b0;
      req_ch.left_sample  <= '0;
      req_ch.right_sample <= '0;
      csr_ch.valid        <= 1'b0;
      csr_ch.index        <= REG_FADE_ENABLE;
      csr_ch.data         <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // disabled after reset: frames pass, every sample bit both ways
      send_frame(SAMPLE_MAX, SAMPLE_MIN);
      send_frame(SAMPLE_MIN, SAMPLE_MAX);
      send_frame('0, -1);
      send_frame(-1, '0);
      send_frame(BITS_0101, BITS_1010);
      send_frame(BITS_1010, BITS_0101);

      // ramp over six frames after two unscaled ones, last on the final one
      program_fade(1'b1, frame_count + 2, frame_count + 8);
      send_frame(SAMPLE_MIN, SAMPLE_MAX);
      send_frame(SAMPLE_MAX, SAMPLE_MIN);
      send_frame(-1, 1);
      send_frame(1, -1);
      send_frame(SAMPLE_MIN, -1);
      send_frame(SAMPLE_MAX, 1);
      send_frame(-1, -1);
      send_frame(SAMPLE_MIN, SAMPLE_MAX);

      // stop below start: no scaling, last still marked
      program_fade(1'b1, '1, frame_count + 3);
      repeat (3) send_frame(random_sample(), random_sample());

      // one-frame ramp at full gain
      program_fade(1'b1, frame_count, frame_count + 1);
      send_frame(SAMPLE_MIN, SAMPLE_MAX);

      // widest divisor, gain just under one
      program_fade(1'b1, '0, '1);
      send_frame(SAMPLE_MAX, SAMPLE_MIN);
      send_frame(SAMPLE_MIN, -1);

      random_sent = 0;
      while (random_sent < RANDOM_FRAMES) begin
         if (random_sent < RANDOM_FRAMES / 3) begin
            send_idle_pct = 38;
            take_idle_pct = 88;
         end else if (random_sent < 2 * RANDOM_FRAMES / 3) begin
            send_idle_pct = 88;
            take_idle_pct = 38;
         end else begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end

         n = (random_sent == 0) ? 40 : $urandom_range(40, 4);
         shape = segment_shape_type'($urandom_range(5));
         // stop lies beyond the segment for every enabled shape, so no frame gets cut early
         case (shape)
            FADE_TO_END: begin
               fade_end   = frame_count + n;
               fade_begin = frame_count + $urandom_range(n - 1);
            end
            FADE_PAST_END: begin
               fade_end   = frame_count + n + $urandom_range(2000, 1);
               fade_begin = $urandom_range(frame_count);
            end
            STOP_BELOW_START: begin
               fade_end   = frame_count + n + $urandom_range(3);
               fade_begin = fade_end + $urandom_range(5000, 1);
            end
            WIDE_RAMP: begin
               fade_end   = ($urandom_range(3) == 0) ? '1 :
                            $urandom_range(32'hFFFF_FFFF, frame_count + n);
               fade_begin = $urandom_range(frame_count);
            end
            UNITY_STEP: begin
               fade_end   = frame_count + n;
               fade_begin = fade_end - 1;
            end
            default: begin
               fade_end   = $urandom_range(1) ? '0 : $urandom();
               fade_begin = $urandom();
            end
         endcase
         program_fade(shape != BYPASS, fade_begin, fade_end);

         if (random_sent == 0) stall_request = 1'b1;
         pause_at = ($urandom_range(7) == 0) ? n / 2 : n;
         for (int i = 0; i < n; i++) begin
            if (i == pause_at) wait_results(0);
            send_frame(random_sample(), random_sample());
         end
         random_sent += n;
      end

      if ($urandom_range(1)) begin
         // ramp down to the stop, then the cut and frames after it
         program_fade(1'b1, frame_count, frame_count + 3);
         repeat (6) send_frame(random_sample(), random_sample());
      end else begin
         // stop at zero cuts the first enabled frame
         program_fade(1'b1, $urandom(), '0);
         repeat (3) send_frame(random_sample(), random_sample());
      end

      // finished holds even with the fade disabled
      program_fade(1'b0, '0, '1);
      repeat (3) send_frame(random_sample(), random_sample());
      wait_results(SETTLE_CYCLES);

      if (fail_count == 0) begin
         $display("[linear_fade_out_envelope] OK");
      end else begin
         $display("[linear_fade_out_envelope] ERROR");
      end
      $finish;
   end

endmodule
